// ===== sv/ifa_pkg.sv =====
// Shared types, constants and a helper function for the integer format to ASCII block.
package ifa_pkg;

   // Field widths of the request and response channels
   localparam int OPCODE_WIDTH = 8;
   localparam int ARG_WIDTH    = 32;
   localparam int CHAR_WIDTH   = 8;
   localparam int WIDE_WIDTH   = 64;
   localparam int DIGIT_WIDTH  = 4;

   // Character stack and command queue sizing
   localparam int STACK_DEPTH  = 32;
   localparam int COUNT_WIDTH  = $clog2(STACK_DEPTH + 1);
   localparam int QUEUE_DEPTH  = 2;

   // Conversion characters
   localparam logic [OPCODE_WIDTH-1:0] OP_D         = 8'h64;
   localparam logic [OPCODE_WIDTH-1:0] OP_I         = 8'h69;
   localparam logic [OPCODE_WIDTH-1:0] OP_U         = 8'h75;
   localparam logic [OPCODE_WIDTH-1:0] OP_B         = 8'h62;
   localparam logic [OPCODE_WIDTH-1:0] OP_O         = 8'h6f;
   localparam logic [OPCODE_WIDTH-1:0] OP_X_LOWER   = 8'h78;
   localparam logic [OPCODE_WIDTH-1:0] OP_X_UPPER   = 8'h58;
   localparam logic [OPCODE_WIDTH-1:0] OP_C         = 8'h63;
   localparam logic [OPCODE_WIDTH-1:0] OP_PERCENT   = 8'h25;

   // Emitted characters
   localparam logic [CHAR_WIDTH-1:0] CHAR_PERCENT = 8'h25;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2d;
   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO   = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [DIGIT_WIDTH-1:0] DEC_BASE    = 4'd10;

   // Divide by ten through the reciprocal: q = (x * DEC_RECIP) >> DEC_SHIFT
   localparam logic [ARG_WIDTH-1:0] DEC_RECIP = 32'hCCCC_CCCD;
   localparam int DEC_SHIFT = 35;

   typedef enum logic [1:0] {
      RADIX_DEC,
      RADIX_BIN,
      RADIX_OCT,
      RADIX_HEX
   } radix_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_PUSH,
      S_SIGN,
      S_EMIT
   } state_type;

   // One classified conversion, as passed from the front end to the back end
   typedef struct packed {
      logic                   is_num;
      radix_type              radix;
      logic                   upper;
      logic                   neg;
      logic [ARG_WIDTH-1:0]   mag;
      logic [CHAR_WIDTH-1:0]  lit_first;
      logic [CHAR_WIDTH-1:0]  lit_second;
      logic                   lit_two;
   } cmd_type;

   // Map a digit value to its ASCII character
   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] digit,
                                                        input logic upper);
      logic [CHAR_WIDTH-1:0] letter_base;
      letter_base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      if (digit < DEC_BASE) begin
         digit_char = ASCII_ZERO + {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, digit};
      end else begin
         digit_char = letter_base + {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, digit}
                      - {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, DEC_BASE};
      end
   endfunction

endpackage

// ===== sv/ifa_req_if.sv =====
// Request channel: conversion character and argument with valid/ready.
interface ifa_req_if;
   import ifa_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OPCODE_WIDTH-1:0] opcode;
   logic [ARG_WIDTH-1:0]    arg_value;

   modport source (output valid, output opcode, output arg_value, input ready);
   modport sink   (input valid, input opcode, input arg_value, output ready);
endinterface

// ===== sv/ifa_rsp_if.sv =====
// Response channel: one ASCII character and end-of-run marker with valid/ready.
interface ifa_rsp_if;
   import ifa_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] out_char;
   logic                  last_char;

   modport source (output valid, output out_char, output last_char, input ready);
   modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ===== sv/ifa_front.sv =====
// Front end: accepts requests and classifies them into conversion commands.
module ifa_front #(
   parameter int VALUE_WIDTH = 32
) (
   ifa_req_if.sink           req_bus,
   input  logic              queue_full,
   output logic              cmd_push,
   output ifa_pkg::cmd_type  cmd
);
   import ifa_pkg::*;

   localparam logic [WIDE_WIDTH-1:0] VALUE_MASK =
      (WIDE_WIDTH'(1) << VALUE_WIDTH) - WIDE_WIDTH'(1);

   logic [WIDE_WIDTH-1:0] masked;
   logic [WIDE_WIDTH-1:0] negated;
   logic                  sign_bit;

   // Accept whenever the queue has room
   assign req_bus.ready = !queue_full;
   assign cmd_push      = req_bus.valid && !queue_full;

   // Trim the argument to the value width and form its magnitude
   assign masked   = {{(WIDE_WIDTH-ARG_WIDTH){1'b0}}, req_bus.arg_value} & VALUE_MASK;
   assign negated  = (~masked + WIDE_WIDTH'(1)) & VALUE_MASK;
   assign sign_bit = masked[VALUE_WIDTH-1];

   // Decode the conversion character
   always_comb begin
      cmd            = '0;
      cmd.radix      = RADIX_DEC;
      cmd.mag        = masked[ARG_WIDTH-1:0];
      cmd.lit_first  = CHAR_PERCENT;
      cmd.lit_second = req_bus.opcode;
      unique case (req_bus.opcode) inside
         OP_D, OP_I: begin
            cmd.is_num = 1'b1;
            cmd.neg    = sign_bit;
            cmd.mag    = sign_bit ? negated[ARG_WIDTH-1:0] : masked[ARG_WIDTH-1:0];
         end
         OP_U: begin
            cmd.is_num = 1'b1;
         end
         OP_B: begin
            cmd.is_num = 1'b1;
            cmd.radix  = RADIX_BIN;
         end
         OP_O: begin
            cmd.is_num = 1'b1;
            cmd.radix  = RADIX_OCT;
         end
         OP_X_LOWER: begin
            cmd.is_num = 1'b1;
            cmd.radix  = RADIX_HEX;
         end
         OP_X_UPPER: begin
            cmd.is_num = 1'b1;
            cmd.radix  = RADIX_HEX;
            cmd.upper  = 1'b1;
         end
         OP_C: begin
            cmd.lit_first = req_bus.arg_value[CHAR_WIDTH-1:0];
         end
         OP_PERCENT: begin
            cmd.lit_first = CHAR_PERCENT;
         end
         default: begin
            // Unknown conversion: echo a percent sign and the character itself
            cmd.lit_two = 1'b1;
         end
      endcase
   end

endmodule

// ===== sv/ifa_queue.sv =====
// Short command queue between the front end and the back end.
module ifa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ifa_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output ifa_pkg::cmd_type  head_cmd,
   output logic              empty
);
   import ifa_pkg::*;

   localparam int PTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0]  PTR_LAST = PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_WIDTH-1:0] QCNT_FULL = QCNT_WIDTH'(QUEUE_DEPTH);

   cmd_type                entries_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]  count_ff, count_in;

   assign full     = (count_ff == QCNT_FULL);
   assign empty    = (count_ff == '0);
   assign head_cmd = entries_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/ifa_back.sv =====
// Back end: generates digits onto a character stack and drains it as the response run.
module ifa_back (
   input  logic              clock,
   input  logic              reset,
   input  ifa_pkg::cmd_type  head_cmd,
   input  logic              empty,
   output logic              pop,
   ifa_rsp_if.source         rsp_bus
);
   import ifa_pkg::*;

   state_type              state_ff, state_in;
   logic [ARG_WIDTH-1:0]   mag_ff, mag_in;
   radix_type              radix_ff, radix_in;
   logic                   upper_ff, upper_in;
   logic                   neg_ff, neg_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [CHAR_WIDTH-1:0]  stack_ff [STACK_DEPTH];
   logic [CHAR_WIDTH-1:0]  stack_in [STACK_DEPTH];
   logic [WIDE_WIDTH-1:0]  prod_ff;

   logic                   push_en;
   logic [CHAR_WIDTH-1:0]  push_char;
   logic [DIGIT_WIDTH-1:0] digit;
   logic [ARG_WIDTH-1:0]   quot;
   logic [ARG_WIDTH-1:0]   rem_full;

   // Present the top of the stack
   assign rsp_bus.valid     = (state_ff == S_EMIT);
   assign rsp_bus.out_char  = stack_ff[0];
   assign rsp_bus.last_char = (count_ff == COUNT_WIDTH'(1));

   // Next state, digit step and stack update
   always_comb begin
      state_in  = state_ff;
      mag_in    = mag_ff;
      radix_in  = radix_ff;
      upper_in  = upper_ff;
      neg_in    = neg_ff;
      count_in  = count_ff;
      stack_in  = stack_ff;
      pop       = 1'b0;
      push_en   = 1'b0;
      push_char = '0;
      digit     = '0;
      quot      = '0;
      rem_full  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               if (head_cmd.is_num) begin
                  mag_in   = head_cmd.mag;
                  radix_in = head_cmd.radix;
                  upper_in = head_cmd.upper;
                  neg_in   = head_cmd.neg;
                  count_in = '0;
                  state_in = (head_cmd.radix == RADIX_DEC) ? S_MUL : S_PUSH;
               end else begin
                  stack_in[0] = head_cmd.lit_first;
                  stack_in[1] = head_cmd.lit_second;
                  count_in    = head_cmd.lit_two ? COUNT_WIDTH'(2) : COUNT_WIDTH'(1);
                  state_in    = S_EMIT;
               end
            end
         end
         S_MUL: begin
            // Reciprocal product lands in prod_ff this cycle
            state_in = S_PUSH;
         end
         S_PUSH: begin
            case (radix_ff)
               RADIX_DEC: begin
                  quot     = ARG_WIDTH'(prod_ff >> DEC_SHIFT);
                  rem_full = mag_ff - ((quot << 3) + (quot << 1));
                  digit    = rem_full[DIGIT_WIDTH-1:0];
               end
               RADIX_BIN: begin
                  quot  = mag_ff >> 1;
                  digit = {{(DIGIT_WIDTH-1){1'b0}}, mag_ff[0]};
               end
               RADIX_OCT: begin
                  quot  = mag_ff >> 3;
                  digit = {1'b0, mag_ff[2:0]};
               end
               RADIX_HEX: begin
                  quot  = mag_ff >> 4;
                  digit = mag_ff[DIGIT_WIDTH-1:0];
               end
            endcase
            push_en   = 1'b1;
            push_char = digit_char(digit, upper_ff);
            mag_in    = quot;
            if (quot == '0) begin
               state_in = neg_ff ? S_SIGN : S_EMIT;
            end else begin
               state_in = (radix_ff == RADIX_DEC) ? S_MUL : S_PUSH;
            end
         end
         S_SIGN: begin
            push_en   = 1'b1;
            push_char = CHAR_MINUS;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            // Drop the top character on each transfer
            if (rsp_bus.ready) begin
               for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                  stack_in[i] = stack_ff[i+1];
               end
               count_in = count_ff - COUNT_WIDTH'(1);
               if (count_ff == COUNT_WIDTH'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // Push a new character; digits arrive least significant first
      if (push_en) begin
         for (int i = STACK_DEPTH - 1; i > 0; i--) begin
            stack_in[i] = stack_ff[i-1];
         end
         stack_in[0] = push_char;
         count_in    = count_ff + COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      radix_ff <= radix_in;
      upper_ff <= upper_in;
      neg_ff   <= neg_in;
      stack_ff <= stack_in;
      prod_ff  <= {{(WIDE_WIDTH-ARG_WIDTH){1'b0}}, mag_ff} *
                  {{(WIDE_WIDTH-ARG_WIDTH){1'b0}}, DEC_RECIP};
   end

endmodule

// ===== sv/integer_format_to_ascii.sv =====
// Top level of the integer format to ASCII block: front end, command queue and back end.
//
// Usage: each request transfer on req_bus carries a printf conversion character
// (opcode) and a 32-bit argument (arg_value). The block answers with a run of
// ASCII characters on rsp_bus, one per transfer, with last_char set on the
// final character. d/i print signed decimal, u unsigned decimal, b/o/x/X binary,
// octal and hex without leading zeros, c the low byte, % a percent sign, and
// any other character a percent sign followed by that character.
// Per item the back end loads the command, then for each decimal digit forms
// the reciprocal product and then the remainder, or for each binary/octal/hex
// digit takes it straight from the low bits, pushes a minus sign if needed,
// then emits the characters; it loads the next command only when the run is
// done. The back end's digit loop and character stack set the pace; the front
// end keeps taking requests into a two-entry queue meanwhile.
// Reset (synchronous, active high) empties the queue and returns the back end
// to idle. When the receiver holds rsp_bus.ready low the current character
// holds and the queue fills, after which req_bus.ready drops.
module integer_format_to_ascii #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   ifa_req_if.sink    req_bus,
   ifa_rsp_if.source  rsp_bus
);
   import ifa_pkg::*;

   logic    cmd_push;
   cmd_type cmd;
   logic    q_full;
   logic    q_empty;
   logic    cmd_pop;
   cmd_type head_cmd;

   ifa_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .req_bus    (req_bus),
      .queue_full (q_full),
      .cmd_push   (cmd_push),
      .cmd        (cmd)
   );

   ifa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .full     (q_full),
      .pop      (cmd_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   ifa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .pop      (cmd_pop),
      .rsp_bus  (rsp_bus)
   );

`ifndef SYNTHESIS
   // Never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !q_full)
      else $error("command pushed into full queue");

   // Never pop an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !q_empty)
      else $error("command popped from empty queue");

   // The back end is idle in the cycle after the final transfer of a run
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && rsp_bus.last_char) |=> !rsp_bus.valid)
      else $error("response valid straight after last character");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the integer format to ASCII block.
`timescale 1ns / 100ps

module tb_top;
   import ifa_pkg::*;

   // Opcodes that fall through to the echo case
   localparam logic [OPCODE_WIDTH-1:0] OP_STRING = 8'h73;
   localparam logic [OPCODE_WIDTH-1:0] OP_NUL    = 8'h00;
   localparam logic [OPCODE_WIDTH-1:0] OP_ALL_ONES = 8'hff;

   localparam int DRAIN_CYCLES = 80;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] ch;
      logic                  last;
   } text_char_type;

   typedef enum {
      SINK_FLOW,
      SINK_PATTERN,
      SINK_RANDOM
   } sink_mode_type;

   logic          clock = 1'b0;
   logic          reset;
   int            error_count = 0;
   int            sink_cycle = 0;
   sink_mode_type sink_mode = SINK_FLOW;
   text_char_type expected_text[$];

   ifa_req_if req_bus ();
   ifa_rsp_if rsp_bus ();

   integer_format_to_ascii #(
      .VALUE_WIDTH(32)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predict the character run for one conversion and queue it
   function automatic void predict_text(input logic [OPCODE_WIDTH-1:0] op,
                                        input logic [ARG_WIDTH-1:0] arg);
      logic [CHAR_WIDTH-1:0] run[$];
      logic [CHAR_WIDTH-1:0] digits[$];
      logic [ARG_WIDTH-1:0]  neg_arg;
      logic [63:0]           mag;
      logic [63:0]           radix;
      logic [63:0]           rem;
      logic                  upper;
      logic                  is_num;
      text_char_type         item;
      is_num = 1'b1;
      upper  = 1'b0;
      radix  = 64'd10;
      mag    = {32'b0, arg};
      case (op) inside
         OP_D, OP_I: begin
            if (arg[ARG_WIDTH-1]) begin
               run.push_back(CHAR_MINUS);
               neg_arg = ~arg + 1'b1;
               mag = {32'b0, neg_arg};
            end
         end
         OP_U: ;
         OP_B: radix = 64'd2;
         OP_O: radix = 64'd8;
         OP_X_LOWER: radix = 64'd16;
         OP_X_UPPER: begin
            radix = 64'd16;
            upper = 1'b1;
         end
         OP_C: begin
            is_num = 1'b0;
            run.push_back(arg[7:0]);
         end
         OP_PERCENT: begin
            is_num = 1'b0;
            run.push_back(CHAR_PERCENT);
         end
         default: begin
            is_num = 1'b0;
            run.push_back(CHAR_PERCENT);
            run.push_back(op);
         end
      endcase
      // Peel digits least significant first, so push to the front
      if (is_num) begin
         do begin
            rem = mag % radix;
            if (rem < 10)
               digits.push_front(ASCII_ZERO + rem[7:0]);
            else
               digits.push_front((upper ? CHAR_UPPER_A : CHAR_LOWER_A) + rem[7:0] - 8'd10);
            mag = mag / radix;
         end while (mag != 0);
         foreach (digits[k]) run.push_back(digits[k]);
      end
      foreach (run[k]) begin
         item.ch   = run[k];
         item.last = (k == run.size() - 1);
         expected_text.push_back(item);
      end
   endfunction

   function automatic logic [OPCODE_WIDTH-1:0] random_opcode();
      if ($urandom_range(0, 9) < 2) return OPCODE_WIDTH'($urandom_range(0, 255));
      case ($urandom_range(0, 8))
         0: return OP_D;
         1: return OP_I;
         2: return OP_U;
         3: return OP_B;
         4: return OP_O;
         5: return OP_X_LOWER;
         6: return OP_X_UPPER;
         7: return OP_C;
         default: return OP_PERCENT;
      endcase
   endfunction

   function automatic logic [ARG_WIDTH-1:0] random_argument();
      logic [ARG_WIDTH-1:0] value;
      case ($urandom_range(0, 5))
         0: value = $urandom_range(0, 99);
         1: value = -$urandom_range(1, 99);
         2: value = 32'h1 << $urandom_range(0, 31);
         3: value = ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff)
                    ^ $urandom_range(0, 1);
         default: value = $urandom;
      endcase
      return value;
   endfunction

   // Drive one item and hold it until the block takes it
   task automatic send_conversion(input logic [OPCODE_WIDTH-1:0] op,
                                  input logic [ARG_WIDTH-1:0] arg);
      req_bus.valid     <= 1'b1;
      req_bus.opcode    <= op;
      req_bus.arg_value <= arg;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_text(op, arg);
   endtask

   task automatic pause_sender(input int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic test_decimal();
      sink_mode = SINK_FLOW;
      send_conversion(OP_D, 32'd0);
      send_conversion(OP_D, 32'd1);
      send_conversion(OP_D, 32'hffff_ffff);
      send_conversion(OP_D, 32'h8000_0000);
      send_conversion(OP_I, 32'h7fff_ffff);
      send_conversion(OP_I, -32'sd123456);
      send_conversion(OP_U, 32'hffff_ffff);
      send_conversion(OP_U, 32'd0);
   endtask

   task automatic test_radix();
      sink_mode = SINK_PATTERN;
      send_conversion(OP_B, 32'd0);
      send_conversion(OP_B, 32'hffff_ffff);
      send_conversion(OP_O, 32'hffff_ffff);
      send_conversion(OP_X_LOWER, 32'hdead_beef);
      send_conversion(OP_X_UPPER, 32'hdead_beef);
      send_conversion(OP_X_LOWER, 32'd0);
   endtask

   task automatic test_literals();
      sink_mode = SINK_RANDOM;
      send_conversion(OP_C, 32'h1234_5641);
      send_conversion(OP_C, 32'h0000_00ff);
      send_conversion(OP_PERCENT, 32'hffff_ffff);
      send_conversion(OP_STRING, 32'd7);
      send_conversion(OP_NUL, 32'd0);
      send_conversion(OP_ALL_ONES, 32'h5555_aaaa);
   endtask

   // Bursts of random items with random gaps between them
   task automatic test_random_conversions(input int item_total, input sink_mode_type mode);
      int burst_left;
      int sent;
      sink_mode  = mode;
      burst_left = 0;
      sent       = 0;
      while (sent < item_total) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            pause_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
         end
         send_conversion(random_opcode(), random_argument());
         burst_left--;
         sent++;
      end
   endtask

   // Receiver stall pattern; hold ready low through reset
   always @(posedge clock) begin
      sink_cycle <= sink_cycle + 1;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         case (sink_mode)
            SINK_FLOW:    rsp_bus.ready <= 1'b1;
            SINK_PATTERN: rsp_bus.ready <= (sink_cycle % 16) < 11 && (sink_cycle % 5) != 2;
            default:      rsp_bus.ready <= $urandom_range(0, 2) != 0;
         endcase
      end
   end

   // Compare each character transfer with the oldest prediction
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_text.size() == 0) begin
            $display("%0t: unexpected character expected none actual %h last %b",
                     $time, rsp_bus.out_char, rsp_bus.last_char);
            error_count++;
         end else begin
            want = expected_text.pop_front();
            if (rsp_bus.out_char !== want.ch) begin
               $display("%0t: out_char mismatch expected %h actual %h",
                        $time, want.ch, rsp_bus.out_char);
               error_count++;
            end
            if (rsp_bus.last_char !== want.last) begin
               $display("%0t: last_char mismatch expected %b actual %b",
                        $time, want.last, rsp_bus.last_char);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.opcode    <= '0;
      req_bus.arg_value <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_decimal();
      test_radix();
      test_literals();
      test_random_conversions(70, SINK_FLOW);
      test_random_conversions(70, SINK_PATTERN);
      test_random_conversions(50, SINK_RANDOM);

      // Drain outstanding characters
      req_bus.valid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule
